/* hw/rtl/csv_card_number_matcher_assert.svh */
// ----------------------------------------------------------------------------
// csv card number matcher assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef CSV_CARD_NUMBER_MATCHER_ASSERT_SVH
`define CSV_CARD_NUMBER_MATCHER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define CNM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csv card number matcher: assertion failed");

// consequent checked in the cycle after the antecedent
`define CNM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csv card number matcher: assertion failed");

`endif

/* hw/rtl/csv_cnm_pkg.sv */
// ----------------------------------------------------------------------------
// csv_cnm_pkg
// shared types and constants of the csv card number matcher
// ----------------------------------------------------------------------------
package csv_cnm_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_LIST  = 2'd1,
    CMD_END   = 2'd2
  } cmd_t;

  localparam logic VERDICT_GRANTED = 1'b0;
  localparam logic VERDICT_DENIED  = 1'b1;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // card number value width and number of uid bytes that carry it
  localparam int ACC_W         = 32;
  localparam int UID_MAX_BYTES = 4;

  typedef struct packed {
    logic valid;
    logic verdict;
  } res_t;

endpackage

/* hw/rtl/csv_cnm_field_match.sv */
// ----------------------------------------------------------------------------
// csv_cnm_field_match
// csv field tracker and card number compare, one list word per cycle while step is high
// ----------------------------------------------------------------------------
module csv_cnm_field_match #(
  parameter int UID_BYTES = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  csv_cnm_pkg::cmd_t    command,
  input  logic [31:0]          swipe_uid,
  input  logic [7:0]           list_byte,
  output csv_cnm_pkg::res_t    result
);
  import csv_cnm_pkg::*;

  localparam int UID_USED = (UID_BYTES < UID_MAX_BYTES) ? UID_BYTES : UID_MAX_BYTES;
  localparam int UID_W    = 8 * UID_USED;
  localparam int SUM_W    = ACC_W + 4;

  typedef enum logic [1:0] {
    FLD_INDEX,
    FLD_NAME,
    FLD_CARD,
    FLD_FLAG
  } field_t;

  field_t             field_r, field_nxt;
  logic               done_r, done_nxt;
  logic               mismatch_r, mismatch_nxt;
  logic               started_r, started_nxt;
  logic               zero_first_r, zero_first_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [UID_W-1:0]   uid_r, uid_nxt;

  logic               is_digit;
  logic [SUM_W-1:0]   sum;
  logic               overflow;
  logic               hit;

  // value * 10 + digit, carried wide enough to see overflow
  assign is_digit = (list_byte >= CH_ZERO) && (list_byte <= CH_NINE);
  assign sum      = SUM_W'({acc_r, 3'b000}) + SUM_W'({acc_r, 1'b0})
                  + SUM_W'(list_byte[3:0]);
  assign overflow = |sum[SUM_W-1:ACC_W];
  assign hit      = !mismatch_r && started_r && (acc_r == ACC_W'(uid_r));

  always_comb begin
    field_nxt      = field_r;
    done_nxt       = done_r;
    mismatch_nxt   = mismatch_r;
    started_nxt    = started_r;
    zero_first_nxt = zero_first_r;
    acc_nxt        = acc_r;
    uid_nxt        = uid_r;
    result         = '{valid: 1'b0, verdict: VERDICT_DENIED};
    if (step) begin
      case (command)
        CMD_START: begin
          uid_nxt        = swipe_uid[UID_W-1:0];
          field_nxt      = FLD_INDEX;
          done_nxt       = 1'b0;
          mismatch_nxt   = 1'b0;
          started_nxt    = 1'b0;
          zero_first_nxt = 1'b0;
          acc_nxt        = '0;
        end
        CMD_END: begin
          if (!done_r) begin
            done_nxt = 1'b1;
            result   = '{valid: 1'b1, verdict: VERDICT_DENIED};
          end
        end
        CMD_LIST: begin
          if (!done_r) begin
            case (field_r)
              FLD_INDEX, FLD_NAME: begin
                if (list_byte == CH_COMMA) begin
                  field_nxt      = (field_r == FLD_INDEX) ? FLD_NAME : FLD_CARD;
                  mismatch_nxt   = 1'b0;
                  started_nxt    = 1'b0;
                  zero_first_nxt = 1'b0;
                  acc_nxt        = '0;
                end
              end
              FLD_CARD: begin
                if (list_byte == CH_COMMA) begin
                  if (hit) begin
                    done_nxt = 1'b1;
                    result   = '{valid: 1'b1, verdict: VERDICT_GRANTED};
                  end else begin
                    field_nxt = FLD_FLAG;
                  end
                end else begin
                  // non digit, too large, or digit after a leading zero
                  if (!is_digit || overflow || (started_r && zero_first_r))
                    mismatch_nxt = 1'b1;
                  if (!started_r)
                    zero_first_nxt = (list_byte == CH_ZERO);
                  started_nxt = 1'b1;
                  acc_nxt     = sum[ACC_W-1:0];
                end
              end
              FLD_FLAG: begin
                if (list_byte == CH_LF) begin
                  field_nxt      = FLD_INDEX;
                  mismatch_nxt   = 1'b0;
                  started_nxt    = 1'b0;
                  zero_first_nxt = 1'b0;
                  acc_nxt        = '0;
                end
              end
              default: field_nxt = FLD_INDEX;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r      <= FLD_INDEX;
      done_r       <= 1'b1;
      mismatch_r   <= 1'b0;
      started_r    <= 1'b0;
      zero_first_r <= 1'b0;
    end else begin
      field_r      <= field_nxt;
      done_r       <= done_nxt;
      mismatch_r   <= mismatch_nxt;
      started_r    <= started_nxt;
      zero_first_r <= zero_first_nxt;
    end
    acc_r <= acc_nxt;
    uid_r <= uid_nxt;
  end

endmodule

/* hw/rtl/csv_card_number_matcher.sv */
// ----------------------------------------------------------------------------
// csv_card_number_matcher
// compares the card number field of streamed csv records against a card uid
// ----------------------------------------------------------------------------
// a result reaches out_valid through the input and result register stages
// throughput: one item per cycle while out_ready is high, as the digit
//   accumulate and compare in the field matcher are combinational
// reset: synchronous active low; idle with no swipe, list words ignored
//   until a start word arrives, no result pending
// ----------------------------------------------------------------------------
module csv_card_number_matcher #(
  parameter int UID_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_swipe_uid,
  input  logic [7:0]  in_list_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_verdict
);
  import csv_cnm_pkg::*;

  // input register stage
  logic        in_valid_r;
  cmd_t        in_command_r;
  logic [31:0] in_swipe_uid_r;
  logic [7:0]  in_list_byte_r;

  // result register stage
  logic        out_valid_r;
  logic        out_verdict_r;

  logic        out_stall;
  logic        step;
  logic        in_accept;
  res_t        result;

  // the held word moves on whenever the result slot is free or being emptied
  assign out_stall = out_valid_r && !out_ready;
  assign step      = in_valid_r && !out_stall;
  assign in_ready  = !in_valid_r || step;
  assign in_accept = in_valid && in_ready;

  csv_cnm_field_match #(
    .UID_BYTES (UID_BYTES)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .command   (in_command_r),
    .swipe_uid (in_swipe_uid_r),
    .list_byte (in_list_byte_r),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept)
        in_valid_r <= 1'b1;
      else if (step)
        in_valid_r <= 1'b0;
      // a processed word either fills the slot or leaves it empty
      if (step)
        out_valid_r <= result.valid;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
    // payload registers
    if (in_accept) begin
      in_command_r   <= cmd_t'(in_command);
      in_swipe_uid_r <= in_swipe_uid;
      in_list_byte_r <= in_list_byte;
    end
    if (step && result.valid)
      out_verdict_r <= result.verdict;
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

endmodule

/* hw/rtl/csv_cnm_checker.sv */
// ----------------------------------------------------------------------------
// csv_cnm_checker
// port level checks of the csv card number matcher, bound to the top level
// ----------------------------------------------------------------------------
`include "csv_card_number_matcher_assert.svh"

module csv_cnm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_command,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_verdict
);
  import csv_cnm_pkg::*;

  // a stalled result holds its value
  `CNM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_verdict))

  // input side only backs up when the result side stalls
  `CNM_ASSERT_SAME(a_in_ready, !out_valid || out_ready, in_ready)

  // a fresh result comes from an accepted word that passed the input and result registers
  `CNM_ASSERT_SAME(a_out_source, $rose(out_valid), $past(in_valid && in_ready, 2))

  // a start word never raises a result by itself
  `CNM_ASSERT_SAME(a_start_quiet, $rose(out_valid), $past(in_command, 2) != CMD_START)

endmodule

bind csv_card_number_matcher csv_cnm_checker u_csv_cnm_checker (.*);
